@@ design/olr_pkg.sv @@
`timescale 1ns / 1ps

package olr_pkg;

  localparam int X_BITS     = 10;
  localparam int COUNT_BITS = 12;
  localparam int Y_W        = 32;
  localparam int RES_W      = 32;

  // accumulator widths; the saturating count keeps every sum inside these
  localparam int SX_W  = X_BITS + COUNT_BITS;
  localparam int SXX_W = 2 * X_BITS + COUNT_BITS;
  localparam int SY_W  = Y_W + COUNT_BITS;
  localparam int SXY_W = Y_W + X_BITS + COUNT_BITS;
  localparam int DEN_W = SXX_W + COUNT_BITS;
  localparam int NUM_W = SY_W + SXX_W + 1;

  // digit-serial multiplier
  localparam int DIG_W    = 4;
  localparam int MC_W     = SXY_W;
  localparam int PP_W     = MC_W + DIG_W + 1;
  localparam int MPD_W    = ((SXX_W + DIG_W - 1) / DIG_W) * DIG_W;
  localparam int NDIG_MAX = MPD_W / DIG_W;
  localparam int DIGI_W   = $clog2(NDIG_MAX);
  localparam int ND_C     = (COUNT_BITS + DIG_W - 1) / DIG_W;
  localparam int ND_SX    = (SX_W + DIG_W - 1) / DIG_W;
  localparam int ND_SXX   = (SXX_W + DIG_W - 1) / DIG_W;

  // divider: quotient bits before saturation; DEN_W + QB equals NUM_W
  localparam int QB    = RES_W + 1;
  localparam int CNT_W = $clog2(QB);

  // product terms, in sequencing order
  localparam int TERM_W = 3;
  localparam logic [TERM_W-1:0] TERM_N_SXX   = 3'd0;
  localparam logic [TERM_W-1:0] TERM_SX_SX   = 3'd1;
  localparam logic [TERM_W-1:0] TERM_N_SXY   = 3'd2;
  localparam logic [TERM_W-1:0] TERM_SX_SY   = 3'd3;
  localparam logic [TERM_W-1:0] TERM_SY_SXX  = 3'd4;
  localparam logic [TERM_W-1:0] TERM_SX_SXY  = 3'd5;
  localparam logic [TERM_W-1:0] TERM_LAST    = TERM_SX_SXY;

  typedef struct packed {
    logic              capture;
    logic              accum;
    logic              mload;
    logic              mstep;
    logic              fold;
    logic              dload;
    logic              dstep;
    logic              dfin;
    logic              publish;
    logic [TERM_W-1:0] term;
    logic [DIGI_W-1:0] dig;
  } cmd_t;

  // index of the top multiplier digit for a term
  function automatic logic [CNT_W-1:0] term_top_digit(input logic [TERM_W-1:0] term);
    logic [CNT_W-1:0] res;
    unique case (term)
      TERM_N_SXX, TERM_N_SXY: res = CNT_W'(ND_C - 1);
      TERM_SY_SXX:            res = CNT_W'(ND_SXX - 1);
      default:                res = CNT_W'(ND_SX - 1);
    endcase
    return res;
  endfunction

endpackage

@@ design/olr_div.sv @@
`timescale 1ns / 1ps

module olr_div (
  input  logic                            clk,
  input  olr_pkg::cmd_t                   cmd,
  input  logic signed [olr_pkg::NUM_W-1:0] num,
  input  logic [olr_pkg::DEN_W-1:0]       den,
  output logic signed [olr_pkg::RES_W-1:0] res
);
  import olr_pkg::*;

  logic                 neg_r, neg_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [QB-1:0]        lo_r, lo_nxt;
  logic [QB-1:0]        q_r, q_nxt;
  logic [RES_W-1:0]     res_r, res_nxt;

  logic [NUM_W-1:0]     mag;
  logic [DEN_W:0]       rem2;
  logic [DEN_W:0]       rem2_sub;
  logic                 ge;
  logic                 rnd;
  logic [QB:0]          qr;
  logic [QB:0]          pos_lim;
  logic [QB:0]          neg_lim;

  assign mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign rem2     = {rem_r, lo_r[QB-1]};
  assign rem2_sub = rem2 - {1'b0, den};
  assign ge       = rem2 >= {1'b0, den};
  assign rnd      = {rem_r, 1'b0} >= {1'b0, den};
  assign qr       = {1'b0, q_r} + (QB+1)'(rnd);
  assign pos_lim  = {{(QB+1-RES_W){1'b0}}, 1'b0, {(RES_W-1){1'b1}}};
  assign neg_lim  = {{(QB+1-RES_W){1'b0}}, 1'b1, {(RES_W-1){1'b0}}};

  always_comb begin
    neg_nxt = neg_r;
    ovf_nxt = ovf_r;
    rem_nxt = rem_r;
    lo_nxt  = lo_r;
    q_nxt   = q_r;
    res_nxt = res_r;
    if (cmd.dload) begin
      neg_nxt = num[NUM_W-1];
      // quotient needs more than QB bits: saturated whatever the rounding
      ovf_nxt = {1'b0, mag} >= {1'b0, den, {QB{1'b0}}};
      rem_nxt = mag[NUM_W-1:QB];
      lo_nxt  = mag[QB-1:0];
      q_nxt   = '0;
    end else if (cmd.dstep) begin
      rem_nxt = ge ? rem2_sub[DEN_W-1:0] : rem2[DEN_W-1:0];
      lo_nxt  = {lo_r[QB-2:0], 1'b0};
      q_nxt   = {q_r[QB-2:0], ge};
    end else if (cmd.dfin) begin
      if (neg_r) begin
        res_nxt = (ovf_r || qr > neg_lim) ? {1'b1, {(RES_W-1){1'b0}}}
                                          : RES_W'(-qr[RES_W-1:0]);
      end else begin
        res_nxt = (ovf_r || qr > pos_lim) ? {1'b0, {(RES_W-1){1'b1}}}
                                          : qr[RES_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
    res_r <= res_nxt;
  end

  assign res = $signed(res_r);

endmodule

@@ design/olr_dp.sv @@
`timescale 1ns / 1ps

module olr_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  olr_pkg::cmd_t                    cmd,
  input  logic [olr_pkg::X_BITS-1:0]       x_coord,
  input  logic signed [olr_pkg::Y_W-1:0]   y_value,
  output logic signed [olr_pkg::RES_W-1:0] slope_value,
  output logic signed [olr_pkg::RES_W-1:0] offset_value,
  output logic                             fit_valid,
  output logic [olr_pkg::COUNT_BITS-1:0]   points_seen,
  output logic                             point_dropped
);
  import olr_pkg::*;

  logic [X_BITS-1:0]        x_r;
  logic signed [Y_W-1:0]    y_r;
  logic [SX_W-1:0]          sum_x_r;
  logic signed [SY_W-1:0]   sum_y_r;
  logic signed [SXY_W-1:0]  sum_xy_r;
  logic [SXX_W-1:0]         sum_xx_r;
  logic [COUNT_BITS-1:0]    count_r;
  logic                     dropped_r;

  logic [MPD_W-1:0]         mp_r;
  logic signed [NUM_W-1:0]  prod_r;
  logic signed [NUM_W-1:0]  den_r;
  logic signed [NUM_W-1:0]  snum_r;
  logic signed [NUM_W-1:0]  onum_r;

  logic signed [RES_W-1:0]  slope_r;
  logic signed [RES_W-1:0]  offset_r;
  logic                     fit_r;
  logic [COUNT_BITS-1:0]    seen_r;
  logic                     drop_out_r;

  logic                     full;
  logic signed [X_BITS+Y_W:0] xy;
  logic [2*X_BITS-1:0]      xx;
  logic signed [MC_W-1:0]   mcand;
  logic [MPD_W-1:0]         mplier;
  logic [DIG_W-1:0]         digit;
  logic signed [PP_W-1:0]   pp;
  logic signed [NUM_W-1:0]  prod_nxt;
  logic [DEN_W-1:0]         den_u;
  logic signed [RES_W-1:0]  slope_q;
  logic signed [RES_W-1:0]  offset_q;

  assign full = count_r == {COUNT_BITS{1'b1}};
  assign xy   = $signed({1'b0, x_r}) * y_r;
  assign xx   = x_r * x_r;

  always_comb begin
    unique case (cmd.term)
      TERM_N_SXX: begin
        mcand  = MC_W'(sum_xx_r);
        mplier = MPD_W'(count_r);
      end
      TERM_SX_SX: begin
        mcand  = MC_W'(sum_x_r);
        mplier = MPD_W'(sum_x_r);
      end
      TERM_N_SXY: begin
        mcand  = sum_xy_r;
        mplier = MPD_W'(count_r);
      end
      TERM_SX_SY: begin
        mcand  = MC_W'(sum_y_r);
        mplier = MPD_W'(sum_x_r);
      end
      TERM_SY_SXX: begin
        mcand  = MC_W'(sum_y_r);
        mplier = MPD_W'(sum_xx_r);
      end
      default: begin
        mcand  = sum_xy_r;
        mplier = MPD_W'(sum_x_r);
      end
    endcase
  end

  assign digit    = mp_r[cmd.dig*DIG_W +: DIG_W];
  assign pp       = mcand * $signed({1'b0, digit});
  assign prod_nxt = (prod_r <<< DIG_W) + {{(NUM_W-PP_W){pp[PP_W-1]}}, pp};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r   <= '0;
      sum_y_r   <= '0;
      sum_xy_r  <= '0;
      sum_xx_r  <= '0;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.accum) begin
      dropped_r <= full;
      if (!full) begin
        sum_x_r  <= sum_x_r + SX_W'(x_r);
        sum_y_r  <= sum_y_r + SY_W'(y_r);
        sum_xy_r <= sum_xy_r + SXY_W'(xy);
        sum_xx_r <= sum_xx_r + SXX_W'(xx);
        count_r  <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= x_coord;
      y_r <= y_value;
    end
    if (cmd.mload) begin
      mp_r   <= mplier;
      prod_r <= '0;
    end else if (cmd.mstep) begin
      prod_r <= prod_nxt;
    end
    if (cmd.accum) begin
      den_r  <= '0;
      snum_r <= '0;
      onum_r <= '0;
    end else if (cmd.fold) begin
      unique case (cmd.term)
        TERM_N_SXX:  den_r  <= den_r + prod_r;
        TERM_SX_SX:  den_r  <= den_r - prod_r;
        TERM_N_SXY:  snum_r <= snum_r + prod_r;
        TERM_SX_SY:  snum_r <= snum_r - prod_r;
        TERM_SY_SXX: onum_r <= onum_r + prod_r;
        TERM_SX_SXY: onum_r <= onum_r - prod_r;
        default: ;
      endcase
    end
    if (cmd.publish) begin
      fit_r      <= den_u != '0;
      slope_r    <= (den_u != '0) ? slope_q : '0;
      offset_r   <= (den_u != '0) ? offset_q : '0;
      seen_r     <= count_r;
      drop_out_r <= dropped_r;
    end
  end

  // the denominator is never negative, so its low bits hold it whole
  assign den_u = den_r[DEN_W-1:0];

  olr_div u_div_slope (
    .clk (clk),
    .cmd (cmd),
    .num (snum_r),
    .den (den_u),
    .res (slope_q)
  );

  olr_div u_div_offset (
    .clk (clk),
    .cmd (cmd),
    .num (onum_r),
    .den (den_u),
    .res (offset_q)
  );

  assign slope_value   = slope_r;
  assign offset_value  = offset_r;
  assign fit_valid     = fit_r;
  assign points_seen   = seen_r;
  assign point_dropped = drop_out_r;

endmodule

@@ design/olr_ctrl.sv @@
`timescale 1ns / 1ps

module olr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output olr_pkg::cmd_t cmd
);
  import olr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACCUM = 4'd1;
  localparam logic [3:0] S_MLOAD = 4'd2;
  localparam logic [3:0] S_MSTEP = 4'd3;
  localparam logic [3:0] S_FOLD  = 4'd4;
  localparam logic [3:0] S_DLOAD = 4'd5;
  localparam logic [3:0] S_DSTEP = 4'd6;
  localparam logic [3:0] S_DFIN  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.term      = term_r;
    cmd.dig       = cnt_r[DIGI_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        term_nxt  = TERM_N_SXX;
        state_nxt = S_MLOAD;
      end
      S_MLOAD: begin
        cmd.mload = 1'b1;
        cnt_nxt   = term_top_digit(term_r);
        state_nxt = S_MSTEP;
      end
      S_MSTEP: begin
        cmd.mstep = 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (term_r == TERM_LAST) begin
          state_nxt = S_DLOAD;
        end else begin
          term_nxt  = term_r + 1'b1;
          state_nxt = S_MLOAD;
        end
      end
      S_DLOAD: begin
        cmd.dload = 1'b1;
        cnt_nxt   = CNT_W'(QB - 1);
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.dstep = 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_DFIN;
      end
      S_DFIN: begin
        cmd.dfin  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the finished fit until the output register is free
        if (slot_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      term_r      <= TERM_N_SXX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

@@ design/online_linear_regression_fit.sv @@
// One point is worked on at a time: in_ready is low from an accepted input beat until its
// result has been published, and a full output register stalls publishing. The 4-bit
// digit-serial multiplier (six products, each with its load and fold) and the two 33-step
// restoring dividers, run side by side, set the pace.
// The output register holds a result while the next point is being worked on.
// Reset (rst_n, synchronous, active low) clears all sums, the count and the handshakes.
`timescale 1ns / 1ps

module online_linear_regression_fit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [olr_pkg::X_BITS-1:0]       in_x_coord,
  input  logic signed [olr_pkg::Y_W-1:0]   in_y_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [olr_pkg::RES_W-1:0] out_slope_value,
  output logic signed [olr_pkg::RES_W-1:0] out_offset_value,
  output logic                             out_fit_valid,
  output logic [olr_pkg::COUNT_BITS-1:0]   out_points_seen,
  output logic                             out_point_dropped
);
  import olr_pkg::*;

  cmd_t cmd;

  olr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  olr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .x_coord       (in_x_coord),
    .y_value       (in_y_value),
    .slope_value   (out_slope_value),
    .offset_value  (out_offset_value),
    .fit_valid     (out_fit_valid),
    .points_seen   (out_points_seen),
    .point_dropped (out_point_dropped)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while a point is in flight");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fit_valid |-> out_slope_value == '0 && out_offset_value == '0)
    else $error("degenerate fit with non-zero slope or offset");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_dropped |-> out_points_seen == {COUNT_BITS{1'b1}})
    else $error("point dropped below full count");

  a_fit_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fit_valid |-> out_points_seen >= COUNT_BITS'(2))
    else $error("fit reported valid with fewer than two points");
`endif

endmodule

@@ bench/online_linear_regression_fit_test.sv @@
`timescale 1ns / 1ps

module online_linear_regression_fit_test;
  import olr_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int MAX_WAIT     = 18;
  localparam int LONG_HOLD    = 600;
  localparam int SETTLE       = 200;
  localparam int RANDOM_POINTS = 1680;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int REPORT_MAX = 10;

  localparam logic [COUNT_BITS-1:0] COUNT_FULL = {COUNT_BITS{1'b1}};
  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};
  localparam logic [X_BITS-1:0] X_TOP = {X_BITS{1'b1}};

  typedef struct packed {
    logic signed [RES_W-1:0]  slope;
    logic signed [RES_W-1:0]  offset;
    logic                     fit_ok;
    logic [COUNT_BITS-1:0]    seen;
    logic                     dropped;
  } fit_t;

  typedef enum int {
    MIX_SPREAD, MIX_STEEP, MIX_NEAR_ZERO, MIX_ON_LINE, MIX_FIXED_X, MIX_CORNERS
  } point_mix_e;

  class line_fit_tracker;
    logic [SX_W-1:0]          sum_x;
    logic signed [SY_W-1:0]   sum_y;
    logic signed [SXY_W-1:0]  sum_xy;
    logic [SXX_W-1:0]         sum_xx;
    logic [COUNT_BITS-1:0]    n_pts;
    fit_t                     pending_fits[$];
    int                       mismatches;

    function new();
      sum_x = '0;
      sum_y = '0;
      sum_xy = '0;
      sum_xx = '0;
      n_pts = '0;
      mismatches = 0;
    endfunction

    // round to nearest, ties away from zero, then clamp to the result width
    function logic signed [RES_W-1:0] rounded_quotient(input logic signed [127:0] num,
                                                        input logic [127:0] den);
      logic [127:0] mag, q, r;
      logic neg;
      neg = num[127];
      mag = neg ? -num : num;
      q = mag / den;
      r = mag % den;
      if (r >= den - r) q = q + 1'b1;
      if (neg) begin
        if (q > 128'h8000_0000) return RES_MIN;
        q = -q;
        return q[RES_W-1:0];
      end
      if (q > 128'h7FFF_FFFF) return RES_MAX;
      return q[RES_W-1:0];
    endfunction

    function void add_point(input logic [X_BITS-1:0] x, input logic signed [Y_W-1:0] y);
      logic signed [127:0] xw, yw, n, sx, sy, sxy, sxx, den;
      fit_t f;
      f.dropped = (n_pts == COUNT_FULL);
      if (!f.dropped) begin
        xw = x;
        yw = y;
        sum_x = sum_x + x;
        sum_y = sum_y + y;
        sum_xy = sum_xy + xw * yw;
        sum_xx = sum_xx + x * x;
        n_pts = n_pts + 1'b1;
      end
      n = n_pts;
      sx = sum_x;
      sy = sum_y;
      sxy = sum_xy;
      sxx = sum_xx;
      den = n * sxx - sx * sx;
      f.seen = n_pts;
      if (den != 0) begin
        f.fit_ok = 1'b1;
        f.slope = rounded_quotient(n * sxy - sx * sy, den);
        f.offset = rounded_quotient(sy * sxx - sx * sxy, den);
      end else begin
        f.fit_ok = 1'b0;
        f.slope = '0;
        f.offset = '0;
      end
      pending_fits.push_back(f);
    endfunction

    function string describe(input fit_t f);
      return $sformatf("slope %0d offset %0d fit_valid %0b seen %0d dropped %0b",
                       f.slope, f.offset, f.fit_ok, f.seen, f.dropped);
    endfunction

    function void check_fit(input logic signed [RES_W-1:0] slope,
                            input logic signed [RES_W-1:0] offset, input logic fit_ok,
                            input logic [COUNT_BITS-1:0] seen, input logic dropped);
      fit_t got, want;
      got = {slope, offset, fit_ok, seen, dropped};
      if (pending_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result beat with no point outstanding: %s", $time, describe(got));
        return;
      end
      want = pending_fits.pop_front();
      if (got.slope !== want.slope || got.offset !== want.offset ||
          got.fit_ok !== want.fit_ok || got.seen !== want.seen ||
          got.dropped !== want.dropped) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: fit mismatch", $time);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [X_BITS-1:0] in_x_coord = '0;
  logic signed [Y_W-1:0] in_y_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [RES_W-1:0] out_slope_value;
  logic signed [RES_W-1:0] out_offset_value;
  logic out_fit_valid;
  logic [COUNT_BITS-1:0] out_points_seen;
  logic out_point_dropped;

  line_fit_tracker tracker;
  int unsigned cycle_count = 0;
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;

  // per-phase shape of the random points
  logic [X_BITS-1:0] steep_base, fixed_x;
  bit steep_up;
  longint line_gain, line_off;

  online_linear_regression_fit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_x_coord        (in_x_coord),
    .in_y_value        (in_y_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_slope_value   (out_slope_value),
    .out_offset_value  (out_offset_value),
    .out_fit_valid     (out_fit_valid),
    .out_points_seen   (out_points_seen),
    .out_point_dropped (out_point_dropped)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("online_linear_regression_fit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_fit(out_slope_value, out_offset_value, out_fit_valid,
                        out_points_seen, out_point_dropped);
    if (rst_n && in_valid && in_ready)
      tracker.add_point(in_x_coord, in_y_value);
  end

  function automatic int draw_wait();
    if (calm) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic void draw_point(input point_mix_e mix, output logic [X_BITS-1:0] x,
                                     output logic signed [Y_W-1:0] y);
    int hi, dip;
    longint v;
    case (mix)
      MIX_STEEP: begin
        hi = $urandom_range(0, 1);
        dip = $urandom_range(0, 255);
        x = steep_base + hi[X_BITS-1:0];
        y = (hi == int'(steep_up)) ? Y_MAX - dip : Y_MIN + dip;
      end
      MIX_NEAR_ZERO: begin
        x = $urandom_range(0, 15);
        y = int'($urandom_range(0, 511)) - 256;
      end
      MIX_ON_LINE: begin
        x = $urandom_range(0, X_TOP);
        v = line_off + line_gain * longint'(int'(x)) + (int'($urandom_range(0, 2047)) - 1024);
        if (v > longint'(Y_MAX)) v = Y_MAX;
        if (v < longint'(Y_MIN)) v = Y_MIN;
        y = v[Y_W-1:0];
      end
      MIX_FIXED_X: begin
        x = fixed_x;
        y = $urandom;
      end
      MIX_CORNERS: begin
        hi = $urandom_range(0, 1);
        x = $urandom_range(0, 1);
        if (hi != 0) x = X_TOP - x;
        case ($urandom_range(0, 4))
          0: y = Y_MIN;
          1: y = Y_MAX;
          2: y = 0;
          3: y = -1;
          default: y = 1;
        endcase
      end
      default: begin
        x = $urandom_range(0, X_TOP);
        y = $urandom;
      end
    endcase
  endfunction

  task automatic send_point(input logic [X_BITS-1:0] x, input logic signed [Y_W-1:0] y,
                            input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_coord <= x;
    in_y_value <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering points until every outstanding fit has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    // let the beat just taken reach the scoreboard first
    @(posedge clk);
    while (tracker.pending_fits.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls per beat, with the odd long hold-off
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = draw_wait();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int phase_left;
    point_mix_e mix;
    logic [X_BITS-1:0] x;
    logic signed [Y_W-1:0] y;
    tracker = new();
    phase_left = 0;
    mix = MIX_STEEP;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first point and equal x: no fit; then a tie that rounds past the top and clamps
    send_point(10'd1, Y_MIN, draw_wait());
    send_point(10'd1, Y_MAX, draw_wait());
    send_point(10'd2, Y_MAX, draw_wait());
    send_point(10'd2, Y_MIN, draw_wait());
    send_point(10'd0, Y_MAX, draw_wait());
    send_point(10'd0, Y_MIN, draw_wait());
    send_point(X_TOP, Y_MAX, draw_wait());
    send_point(X_TOP, Y_MIN, draw_wait());
    send_point(X_TOP, 32'sd0, draw_wait());
    send_point(10'd0, 32'sd0, draw_wait());
    send_point(10'd512, -32'sd1, draw_wait());
    send_point(10'd511, 32'sd1, draw_wait());
    send_point(10'h2AA, 32'hAAAA_AAAA, draw_wait());
    send_point(10'h155, 32'h5555_5555, draw_wait());
    send_point(X_TOP, Y_MAX, draw_wait());
    send_point(10'd1, -32'sd1, draw_wait());
    send_point(10'd0, 32'sd1, draw_wait());
    send_point(X_TOP - 1'b1, Y_MIN, draw_wait());
    wait_for_drain();

    for (int i = 0; i < RANDOM_POINTS; i++) begin
      if (phase_left == 0) begin
        if (i != 0) mix = point_mix_e'($urandom_range(0, 5));
        phase_left = $urandom_range(40, 300);
        calm = ($urandom_range(0, 5) == 0);
        steep_base = $urandom_range(0, X_TOP - 1);
        steep_up = $urandom_range(0, 1);
        fixed_x = $urandom_range(0, X_TOP);
        line_gain = longint'(int'($urandom_range(0, 1 << 22))) - (1 << 21);
        line_off = longint'(int'($urandom));
      end
      if (i == 300 || i == 1000) hold_off_req = 1'b1;
      if (i == 600 || i == 1400) wait_for_drain();
      draw_point(mix, x, y);
      send_point(x, y, draw_wait());
      phase_left--;
    end

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_fits.size() == 0)
      $display("online_linear_regression_fit verification clean");
    else
      $display("online_linear_regression_fit verification failed");
    $finish;
  end

endmodule

@@ online_linear_regression_fit.f @@
design/olr_pkg.sv
design/olr_div.sv
design/olr_dp.sv
design/olr_ctrl.sv
design/online_linear_regression_fit.sv
bench/online_linear_regression_fit_test.sv
